// ===== hw/rtl/psps_pkg.sv =====
// ---------------------------------------------------------------------------
// psps_pkg
// shared types and constants for the positive score partition sort block
// ---------------------------------------------------------------------------
package psps_pkg;

	localparam int unsigned MOVE_W  = 32;
	localparam int unsigned SCORE_W = 32;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned ENTRY_W = MOVE_W + SCORE_W;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PINIT,
		ST_PF_RD,
		ST_PF_CK,
		ST_PB_RD,
		ST_PB_CK,
		ST_PB_SW,
		ST_SORT_INIT,
		ST_SC_START,
		ST_SC_RD,
		ST_SC_CK,
		ST_EMIT,
		ST_NONE,
		ST_WAIT
	} psps_state_t;

	// controller to datapath
	typedef struct packed {
		logic in_ready;
		logic part_init;
		logic rd_b;
		logic rd_idx;
		logic f_inc;
		logic hold_ef;
		logic b_dec;
		logic wr_f;
		logic wr_b;
		logic sort_init;
		logic scan_init;
		logic scan_upd;
		logic emit;
		logic none_out;
		logic run_clear;
	} psps_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_take;
		logic in_final;
		logic f_eq_b;
		logic rd_pos;
		logic idx_end;
		logic pos_zero;
		logic out_taken;
		logic out_last;
	} psps_stat_t;

endpackage

// ===== hw/rtl/psps_ctrl.sv =====
// ---------------------------------------------------------------------------
// psps_ctrl
// sequencer for load, in-place partition, selection ranking and output
// ---------------------------------------------------------------------------
module psps_ctrl import psps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  psps_stat_t stat,
	output psps_cmd_t  cmd
);

	psps_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:      if (stat.in_take && stat.in_final) state_d = ST_PINIT;
			ST_PINIT:     state_d = ST_PF_RD;
			ST_PF_RD:     state_d = stat.f_eq_b ? ST_SORT_INIT : ST_PF_CK;
			ST_PF_CK:     state_d = stat.rd_pos ? ST_PF_RD : ST_PB_RD;
			ST_PB_RD:     state_d = stat.f_eq_b ? ST_SORT_INIT : ST_PB_CK;
			ST_PB_CK:     state_d = stat.rd_pos ? ST_PB_SW : ST_PB_RD;
			ST_PB_SW:     state_d = ST_PF_RD;
			ST_SORT_INIT: state_d = stat.pos_zero ? ST_NONE : ST_SC_START;
			ST_SC_START:  state_d = ST_SC_RD;
			ST_SC_RD:     state_d = stat.idx_end ? ST_EMIT : ST_SC_CK;
			ST_SC_CK:     state_d = ST_SC_RD;
			ST_EMIT:      state_d = ST_WAIT;
			ST_NONE:      state_d = ST_WAIT;
			ST_WAIT: begin
				if (stat.out_taken) state_d = stat.out_last ? ST_LOAD : ST_SC_START;
			end
			default:      state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_LOAD:      cmd.in_ready = 1'b1;
			ST_PINIT:     cmd.part_init = 1'b1;
			ST_PF_RD:     ;
			ST_PF_CK: begin
				if (stat.rd_pos) begin
					cmd.f_inc = 1'b1;
				end else begin
					cmd.hold_ef = 1'b1;
					cmd.b_dec   = 1'b1;
				end
			end
			ST_PB_RD:     cmd.rd_b = 1'b1;
			ST_PB_CK: begin
				if (stat.rd_pos) cmd.wr_f = 1'b1;
				else cmd.b_dec = 1'b1;
			end
			ST_PB_SW: begin
				cmd.wr_b  = 1'b1;
				cmd.f_inc = 1'b1;
			end
			ST_SORT_INIT: cmd.sort_init = 1'b1;
			ST_SC_START:  cmd.scan_init = 1'b1;
			ST_SC_RD:     cmd.rd_idx = 1'b1;
			ST_SC_CK:     cmd.scan_upd = 1'b1;
			ST_EMIT:      cmd.emit = 1'b1;
			ST_NONE:      cmd.none_out = 1'b1;
			ST_WAIT:      cmd.run_clear = stat.out_taken && stat.out_last;
			default:      ;
		endcase
	end

endmodule

// ===== hw/rtl/psps_dp.sv =====
// ---------------------------------------------------------------------------
// psps_dp
// entry memory, partition cursors, ranking scan and output register
// ---------------------------------------------------------------------------
module psps_dp import psps_pkg::*; #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  psps_cmd_t            cmd,
	output psps_stat_t           stat,
	input  logic                 in_valid,
	input  logic [MOVE_W-1:0]    in_move,
	input  logic [SCORE_W-1:0]   in_score,
	input  logic                 in_final,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [MOVE_W-1:0]    out_move,
	output logic [SCORE_W-1:0]   out_score,
	output logic [CNT_W-1:0]     out_count,
	output logic                 out_none,
	output logic                 out_ovf,
	output logic                 out_last
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [ENTRY_W-1:0] mem [CAPACITY];
	logic [ENTRY_W-1:0] rdata_q;
	logic [ENTRY_W-1:0] ef_q;
	logic [CW-1:0]      cnt_q, f_q, b_q, idx_q, k_q;
	logic               ovf_q;
	logic [CAPACITY-1:0] used_q;
	logic               best_vld_q;
	logic [ENTRY_W-1:0] best_q;
	logic [AW-1:0]      best_idx_q;
	logic               out_valid_q;

	logic               take, store_ok, wen;
	logic [AW-1:0]      waddr, raddr;
	logic [ENTRY_W-1:0] wdata;
	logic               better;

	assign take     = in_valid && cmd.in_ready;
	assign store_ok = cnt_q < CW'(CAPACITY);

	always_comb begin
		wen   = 1'b0;
		waddr = f_q[AW-1:0];
		wdata = rdata_q;
		if (take && store_ok) begin
			wen   = 1'b1;
			waddr = cnt_q[AW-1:0];
			wdata = {in_score, in_move};
		end else if (cmd.wr_f) begin
			wen   = 1'b1;
			waddr = f_q[AW-1:0];
			wdata = rdata_q;
		end else if (cmd.wr_b) begin
			wen   = 1'b1;
			waddr = b_q[AW-1:0];
			wdata = ef_q;
		end
	end

	always_comb begin
		raddr = f_q[AW-1:0];
		if (cmd.rd_b) raddr = b_q[AW-1:0];
		else if (cmd.rd_idx) raddr = idx_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (wen) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// strictly greater keeps the earliest index on ties, following the order left by the partition
	assign better = !used_q[idx_q[AW-1:0]] && (!best_vld_q ||
		($signed(rdata_q[ENTRY_W-1:MOVE_W]) > $signed(best_q[ENTRY_W-1:MOVE_W])));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			f_q         <= '0;
			b_q         <= '0;
			idx_q       <= '0;
			k_q         <= '0;
			used_q      <= '0;
			best_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (store_ok) cnt_q <= cnt_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (cmd.part_init) begin
				f_q <= '0;
				b_q <= cnt_q;
			end
			if (cmd.f_inc) f_q <= f_q + 1'b1;
			if (cmd.b_dec) b_q <= b_q - 1'b1;
			if (cmd.sort_init) begin
				used_q <= '0;
				k_q    <= '0;
			end
			if (cmd.scan_init) begin
				idx_q      <= '0;
				best_vld_q <= 1'b0;
			end
			if (cmd.scan_upd) begin
				idx_q <= idx_q + 1'b1;
				if (better) best_vld_q <= 1'b1;
			end
			if (cmd.emit) begin
				used_q[best_idx_q] <= 1'b1;
				k_q <= k_q + 1'b1;
			end
			if (cmd.emit || cmd.none_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cmd.run_clear) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hold_ef) ef_q <= rdata_q;
		if (cmd.scan_upd && better) begin
			best_q     <= rdata_q;
			best_idx_q <= idx_q[AW-1:0];
		end
		if (cmd.emit) begin
			out_move  <= best_q[MOVE_W-1:0];
			out_score <= best_q[ENTRY_W-1:MOVE_W];
			out_count <= CNT_W'(f_q);
			out_none  <= 1'b0;
			out_ovf   <= ovf_q;
			out_last  <= (k_q + 1'b1) == f_q;
		end else if (cmd.none_out) begin
			out_move  <= '0;
			out_score <= '0;
			out_count <= '0;
			out_none  <= 1'b1;
			out_ovf   <= ovf_q;
			out_last  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat.in_take   = take;
		stat.in_final  = in_final;
		stat.f_eq_b    = f_q == b_q;
		stat.rd_pos    = $signed(rdata_q[ENTRY_W-1:MOVE_W]) > 0;
		stat.idx_end   = idx_q == f_q;
		stat.pos_zero  = f_q == '0;
		stat.out_taken = out_valid_q && out_ready;
		stat.out_last  = out_last;
	end

endmodule

// ===== hw/rtl/positive_score_partition_sort.sv =====
// ---------------------------------------------------------------------------
// positive_score_partition_sort
// loads a list of (move, score) requests, partitions positives to the front,
// then emits them ranked by score, highest first, ties in partition order, or
// a single none_positive result when the list holds no positive score
// loading: one request per cycle; the partition then reads and checks each
//   entry that a cursor visits, writing both ends on a swap, on the single read port
// ranking: each result scans the positive prefix for the highest unused score;
//   the next scan waits until the current result is taken
// reset: arst_n clears counters, flags and the sequencer; the entry memory is
//   not cleared, only entries written in the current list are read
// ---------------------------------------------------------------------------
module positive_score_partition_sort import psps_pkg::*; #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // move_code[31:0], move_score[63:32]
	input  logic        s_tlast,   // final_item
	// ranked results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // out_move[31:0], out_score[63:32],
	                               // positive_count[70:64], zero pad[71]
	output logic [1:0]  m_tuser,   // none_positive[0], overflowed[1]
	output logic        m_tlast    // last_result
);

	psps_cmd_t  cmd;
	psps_stat_t stat;

	logic [MOVE_W-1:0]  res_move;
	logic [SCORE_W-1:0] res_score;
	logic [CNT_W-1:0]   res_count;
	logic               res_none, res_ovf;

	// sequencer: load, partition, selection ranking, output handshake
	psps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// storage, cursors and the output register
	psps_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_valid  (s_tvalid),
		.in_move   (s_tdata[31:0]),
		.in_score  (s_tdata[63:32]),
		.in_final  (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_move  (res_move),
		.out_score (res_score),
		.out_count (res_count),
		.out_none  (res_none),
		.out_ovf   (res_ovf),
		.out_last  (m_tlast)
	);

	// ready only while loading a list
	assign s_tready = cmd.in_ready;
	assign m_tdata  = {1'b0, res_count, res_score, res_move};
	assign m_tuser  = {res_ovf, res_none};

endmodule
